// File: hdl/psc_pkg.sv
// Package for the pressure compensation block: register map, widths and shift amounts.
`default_nettype none
package psc_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned WordW   = 16;
  localparam int unsigned CountW  = 10;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned IdxW    = 3;

  // Position of the 10-bit count inside a raw conversion word.
  localparam int unsigned CountLsb = 6;

  // Fixed-point shift amounts of the compensation polynomial.
  localparam int unsigned ShB1   = 14;
  localparam int unsigned ShA11  = 11;
  localparam int unsigned ShB2   = 15;
  localparam int unsigned ShA2   = 16;
  localparam int unsigned ShA0   = 10;
  localparam int unsigned ShPc   = 13;

  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic [CountW-1:0]       count_t;

  typedef enum logic [IdxW-1:0] {
    REG_OFFSET_A0    = 3'd0,
    REG_SLOPE_B1     = 3'd1,
    REG_TEMP_COEF_B2 = 3'd2,
    REG_CROSS_C12    = 3'd3,
    REG_PRESSURE_C11 = 3'd4,
    REG_TEMP_SQ_C22  = 3'd5
  } reg_idx_t;

endpackage
`default_nettype wire

// File: hdl/pressure_sensor_compensation.sv
// Top level of the barometric pressure compensation block: register file and six-stage pipeline.
`default_nettype none
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  --------------------------------------------
//  in_      input      in_valid / in_stall      in_pressure_word, in_temperature_word
//  out_     output     out_valid / out_stall    out_compensated_pressure, out_temperature_count
//  cfg      input      psel/penable/pwrite      paddr, pwdata, prdata, pready (always high)
//
// One transfer can be accepted in every cycle, as long as no result is held on the output
// under out_stall. The depth is set by the polynomial's chain of three multiply and add-shift
// steps, each product and each sum having a stage of its own.
// Reset (rst_n low, synchronous) clears the coefficients to zero and empties the pipeline.
// The whole pipeline advances together: while a result is held on the output under out_stall,
// every stage freezes and in_stall is raised, so nothing is lost or repeated. Bubbles move
// forward freely when the output stage is empty.
//
module pressure_sensor_compensation (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [psc_pkg::WordW-1:0]     in_pressure_word,
  input  wire logic [psc_pkg::WordW-1:0]     in_temperature_word,
  // Result channel
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [psc_pkg::WordW-1:0] out_compensated_pressure,
  output      logic [psc_pkg::CountW-1:0]    out_temperature_count,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [psc_pkg::AddrW-1:0]     paddr,
  input  wire logic [psc_pkg::DataW-1:0]     pwdata,
  output      logic [psc_pkg::DataW-1:0]     prdata,
  output      logic                          pready
);

  // ---------------------------------------------------------------------------
  // Calibration registers. Only the low 16 bits of a written word are kept, and a
  // write to an address beyond the sixth register has no effect.
  // ---------------------------------------------------------------------------
  psc_pkg::coef_t a0_r, b1_r, b2_r, c12_r, c11_r, c22_r;
  psc_pkg::reg_idx_t cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = psc_pkg::reg_idx_t'(paddr[psc_pkg::AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r  <= '0;
      b1_r  <= '0;
      b2_r  <= '0;
      c12_r <= '0;
      c11_r <= '0;
      c22_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        psc_pkg::REG_OFFSET_A0:    a0_r  <= pwdata[psc_pkg::CoefW-1:0];
        psc_pkg::REG_SLOPE_B1:     b1_r  <= pwdata[psc_pkg::CoefW-1:0];
        psc_pkg::REG_TEMP_COEF_B2: b2_r  <= pwdata[psc_pkg::CoefW-1:0];
        psc_pkg::REG_CROSS_C12:    c12_r <= pwdata[psc_pkg::CoefW-1:0];
        psc_pkg::REG_PRESSURE_C11: c11_r <= pwdata[psc_pkg::CoefW-1:0];
        psc_pkg::REG_TEMP_SQ_C22:  c22_r <= pwdata[psc_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the coefficient sign-extended to the bus width.
  always_comb begin
    case (cfg_idx)
      psc_pkg::REG_OFFSET_A0:    prdata = psc_pkg::DataW'(a0_r);
      psc_pkg::REG_SLOPE_B1:     prdata = psc_pkg::DataW'(b1_r);
      psc_pkg::REG_TEMP_COEF_B2: prdata = psc_pkg::DataW'(b2_r);
      psc_pkg::REG_CROSS_C12:    prdata = psc_pkg::DataW'(c12_r);
      psc_pkg::REG_PRESSURE_C11: prdata = psc_pkg::DataW'(c11_r);
      psc_pkg::REG_TEMP_SQ_C22:  prdata = psc_pkg::DataW'(c22_r);
      default:                   prdata = '0;
    endcase
  end

  // Sign-extended copies of the coefficients in the accumulator width.
  psc_pkg::acc_t a0_x, b1_x, b2_x;
  assign a0_x = psc_pkg::acc_t'(a0_r);
  assign b1_x = psc_pkg::acc_t'(b1_r);
  assign b2_x = psc_pkg::acc_t'(b2_r);

  // ---------------------------------------------------------------------------
  // Pipeline control. All stages share one enable; the pipeline only holds when a
  // finished result is waiting on the output and the receiver is stalling.
  // ---------------------------------------------------------------------------
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: extract the counts and form the three coefficient-by-count products.
  // ---------------------------------------------------------------------------
  psc_pkg::count_t padc_in, tadc_in;
  logic signed [psc_pkg::CountW:0] padc_in_s, tadc_in_s;
  psc_pkg::acc_t c11x1_nxt, c12x2_nxt, c22x2_nxt;
  psc_pkg::count_t padc1_r, tadc1_r;
  psc_pkg::acc_t c11x1_1_r, c12x2_1_r, c22x2_1_r;

  assign padc_in   = in_pressure_word[psc_pkg::WordW-1:psc_pkg::CountLsb];
  assign tadc_in   = in_temperature_word[psc_pkg::WordW-1:psc_pkg::CountLsb];
  assign padc_in_s = $signed({1'b0, padc_in});
  assign tadc_in_s = $signed({1'b0, tadc_in});
  assign c11x1_nxt = psc_pkg::acc_t'(c11_r) * psc_pkg::acc_t'(padc_in_s);
  assign c12x2_nxt = psc_pkg::acc_t'(c12_r) * psc_pkg::acc_t'(tadc_in_s);
  assign c22x2_nxt = psc_pkg::acc_t'(c22_r) * psc_pkg::acc_t'(tadc_in_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      padc1_r   <= padc_in;
      tadc1_r   <= tadc_in;
      c11x1_1_r <= c11x1_nxt;
      c12x2_1_r <= c12x2_nxt;
      c22x2_1_r <= c22x2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: a11 and a2, each one add and an arithmetic shift.
  // ---------------------------------------------------------------------------
  psc_pkg::acc_t a11_sum, a11_nxt, a2_sum, a2_nxt;
  psc_pkg::count_t padc2_r, tadc2_r;
  psc_pkg::acc_t c12x2_2_r, a11_2_r, a2_2_r;

  assign a11_sum = (b1_x <<< psc_pkg::ShB1) + c11x1_1_r;
  assign a11_nxt = a11_sum >>> psc_pkg::ShB1;
  assign a2_sum  = (b2_x <<< psc_pkg::ShB2) + (c22x2_1_r >>> 1);
  assign a2_nxt  = a2_sum >>> psc_pkg::ShA2;

  always_ff @(posedge clk) begin
    if (adv) begin
      padc2_r   <= padc1_r;
      tadc2_r   <= tadc1_r;
      c12x2_2_r <= c12x2_1_r;
      a11_2_r   <= a11_nxt;
      a2_2_r    <= a2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: a1 from a11, and the a2-by-temperature product.
  // ---------------------------------------------------------------------------
  psc_pkg::acc_t a1_sum, a1_nxt, a2x2_nxt;
  psc_pkg::count_t padc3_r, tadc3_r;
  psc_pkg::acc_t a1_3_r, a2x2_3_r;

  assign a1_sum   = (a11_2_r <<< psc_pkg::ShA11) + c12x2_2_r;
  assign a1_nxt   = a1_sum >>> psc_pkg::ShA11;
  assign a2x2_nxt = a2_2_r * psc_pkg::acc_t'($signed({1'b0, tadc2_r}));

  always_ff @(posedge clk) begin
    if (adv) begin
      padc3_r  <= padc2_r;
      tadc3_r  <= tadc2_r;
      a1_3_r   <= a1_nxt;
      a2x2_3_r <= a2x2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: the a1-by-pressure product.
  // ---------------------------------------------------------------------------
  psc_pkg::acc_t a1x1_nxt;
  psc_pkg::count_t tadc4_r;
  psc_pkg::acc_t a1x1_4_r, a2x2_4_r;

  assign a1x1_nxt = a1_3_r * psc_pkg::acc_t'($signed({1'b0, padc3_r}));

  always_ff @(posedge clk) begin
    if (adv) begin
      tadc4_r  <= tadc3_r;
      a1x1_4_r <= a1x1_nxt;
      a2x2_4_r <= a2x2_3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: y1, the offset term.
  // ---------------------------------------------------------------------------
  psc_pkg::acc_t y1_sum, y1_nxt;
  psc_pkg::count_t tadc5_r;
  psc_pkg::acc_t y1_5_r, a2x2_5_r;

  assign y1_sum = (a0_x <<< psc_pkg::ShA0) + a1x1_4_r;
  assign y1_nxt = y1_sum >>> psc_pkg::ShA0;

  always_ff @(posedge clk) begin
    if (adv) begin
      tadc5_r  <= tadc4_r;
      y1_5_r   <= y1_nxt;
      a2x2_5_r <= a2x2_4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: the final sum, cut to 16 bits, held in the output register.
  // ---------------------------------------------------------------------------
  psc_pkg::acc_t pc_sum, pc_full;
  logic signed [psc_pkg::WordW-1:0] pcomp_r;
  psc_pkg::count_t tadc6_r;

  assign pc_sum  = (y1_5_r <<< psc_pkg::ShA0) + a2x2_5_r;
  assign pc_full = pc_sum >>> psc_pkg::ShPc;

  always_ff @(posedge clk) begin
    if (adv) begin
      pcomp_r <= pc_full[psc_pkg::WordW-1:0];
      tadc6_r <= tadc5_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_compensated_pressure = pcomp_r;
  assign out_temperature_count    = tadc6_r;

endmodule
`default_nettype wire
